>>> src/lfm_pkg.sv
// ---------------------------------------------------------------------------
// lfm_pkg: shared types, constants and functions
// Widths, register codes, the sensor lookup and the motor clamp helpers for
// the line follower PID motor mixer.
// ---------------------------------------------------------------------------
package lfm_pkg;

   // Field widths
   localparam int PAT_W   = 7;
   localparam int ERR_W   = 11;
   localparam int SUM_W   = 24;
   localparam int GAIN_W  = 10;
   localparam int SPD_W   = 11;
   localparam int DUTY_W  = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 11;

   // Back end arithmetic widths
   localparam int P_W     = 22;            // gain (11s) x error (11s)
   localparam int I_W     = 35;            // gain (11s) x sum (24s)
   localparam int CORR_W  = 36;            // sum of the three terms
   localparam int MAG_W   = 19;            // magnitude below the saturation limit
   localparam int RCP_W   = 20;
   localparam int PROD_W  = MAG_W + RCP_W;
   localparam int Q_W     = 13;            // quotient magnitude
   localparam int CQ_W    = Q_W + 1;       // signed correction
   localparam int MIX_W   = 15;            // base +/- correction

   // Divide by 100: q = (m * RECIP) >> RECIP_SHIFT is exact for m < 2^MAG_W.
   // Above Q_MAX*100 the quotient is pinned to Q_MAX; that already drives
   // every command past any floor or ceiling.
   localparam logic [RCP_W-1:0]  RECIP       = 20'd671089;
   localparam int                RECIP_SHIFT = 26;
   localparam logic [Q_W-1:0]    Q_MAX       = 13'd4095;
   localparam logic [CORR_W-1:0] Q_LIMIT     = 36'd409500;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7FFFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = 24'sh800000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPD_FLOOR  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPD_CEIL   = 3'd5;

   // Mid queue depth
   localparam int MQ_DEPTH = 4;
   localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
   localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);

   typedef struct packed {
      logic [GAIN_W-1:0]       prop_gain;
      logic [GAIN_W-1:0]       integ_gain;
      logic [GAIN_W-1:0]       deriv_gain;
      logic [GAIN_W-1:0]       base_speed;
      logic signed [SPD_W-1:0] speed_floor;
      logic [GAIN_W-1:0]       speed_ceiling;
   } cfg_type;

   // Classified sample, front to back
   typedef struct packed {
      logic signed [ERR_W-1:0] err;
      logic signed [ERR_W-1:0] delta;
      logic signed [SUM_W-1:0] sum;
      logic                    known;
   } mq_entry_type;

   typedef struct packed {
      logic                    known;
      logic signed [ERR_W-1:0] err;
   } lookup_type;

   typedef struct packed {
      logic signed [SPD_W-1:0] left_speed;
      logic signed [SPD_W-1:0] right_speed;
      logic                    left_reverse;
      logic                    right_reverse;
      logic [DUTY_W-1:0]       left_duty;
      logic [DUTY_W-1:0]       right_duty;
      logic                    pattern_known;
   } rsp_type;

   // Position error (hundredths) for a set of sensors seeing the line
   function automatic lookup_type lookup(input logic [PAT_W-1:0] zeros);
      lookup_type r;
      r.known = 1'b1;
      case (zeros)
         7'h01:   r.err = -11'sd500;
         7'h03:   r.err = -11'sd400;
         7'h02:   r.err = -11'sd300;
         7'h06:   r.err = -11'sd120;
         7'h04:   r.err = -11'sd80;
         7'h0C:   r.err = -11'sd15;
         7'h08:   r.err = 11'sd0;
         7'h18:   r.err = 11'sd15;
         7'h10:   r.err = 11'sd80;
         7'h30:   r.err = 11'sd120;
         7'h20:   r.err = 11'sd300;
         7'h60:   r.err = 11'sd400;
         7'h40:   r.err = 11'sd500;
         default: begin
            r.known = 1'b0;
            r.err   = 11'sd0;
         end
      endcase
      return r;
   endfunction

   // Floor is tested first, then the ceiling
   function automatic logic signed [SPD_W-1:0] clamp_cmd(
      input logic signed [MIX_W-1:0] x,
      input logic signed [SPD_W-1:0] flr,
      input logic [GAIN_W-1:0]       ceil);
      logic signed [MIX_W-1:0] f;
      logic signed [MIX_W-1:0] c;
      f = MIX_W'(flr);
      c = $signed({(MIX_W-GAIN_W)'(0), ceil});
      if (x < f)
         return flr;
      else if (x > c)
         return $signed({1'b0, ceil});
      else
         return x[SPD_W-1:0];
   endfunction

   // Magnitude of a command, most negative value saturates
   function automatic logic [DUTY_W-1:0] duty_of(input logic signed [SPD_W-1:0] x);
      logic [SPD_W-1:0] a;
      a = x[SPD_W-1] ? SPD_W'(-x) : SPD_W'(x);
      return a[SPD_W-1] ? {DUTY_W{1'b1}} : a[DUTY_W-1:0];
   endfunction

endpackage

>>> src/lfm_front.sv
// ---------------------------------------------------------------------------
// lfm_front: sample classifier and error state
// Maps each sensor sample to a position error, keeps the held error and the
// saturating integral, and hands the result to the mid queue.
// ---------------------------------------------------------------------------
module lfm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [lfm_pkg::PAT_W-1:0]     req_line_pattern,
   input  logic                          mq_full,
   output logic                          mq_push,
   output lfm_pkg::mq_entry_type         mq_entry
);

   logic signed [lfm_pkg::ERR_W-1:0] held_ff, held_in;
   logic signed [lfm_pkg::SUM_W-1:0] sum_ff, sum_in;
   lfm_pkg::lookup_type              lk;
   logic signed [lfm_pkg::ERR_W-1:0] err;
   logic signed [lfm_pkg::SUM_W:0]   sum_wide;
   logic signed [lfm_pkg::SUM_W-1:0] sum_sat;

   assign req_full = mq_full;
   assign mq_push  = req_push && !mq_full;

   // classify and integrate
   always_comb begin
      lk       = lfm_pkg::lookup(~req_line_pattern);
      err      = lk.known ? lk.err : held_ff;
      sum_wide = (lfm_pkg::SUM_W+1)'(sum_ff) + (lfm_pkg::SUM_W+1)'(err);
      if (sum_wide[lfm_pkg::SUM_W] != sum_wide[lfm_pkg::SUM_W-1])
         sum_sat = sum_wide[lfm_pkg::SUM_W] ? lfm_pkg::SUM_MIN : lfm_pkg::SUM_MAX;
      else
         sum_sat = sum_wide[lfm_pkg::SUM_W-1:0];
      mq_entry.err   = err;
      mq_entry.delta = err - held_ff;
      mq_entry.sum   = sum_sat;
      mq_entry.known = lk.known;
   end

   // state advances on each input transfer
   always_comb begin
      held_in = held_ff;
      sum_in  = sum_ff;
      if (mq_push) begin
         held_in = err;
         sum_in  = sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         sum_ff  <= '0;
      end else begin
         held_ff <= held_in;
         sum_ff  <= sum_in;
      end
   end

endmodule

>>> src/lfm_queue.sv
// ---------------------------------------------------------------------------
// lfm_queue: mid queue between front and back
// Small register FIFO of classified samples, so either side can stall alone.
// ---------------------------------------------------------------------------
module lfm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lfm_pkg::mq_entry_type wr_data,
   output logic                  full,
   input  logic                  pop,
   output lfm_pkg::mq_entry_type rd_data,
   output logic                  empty
);

   lfm_pkg::mq_entry_type               mem_ff [lfm_pkg::MQ_DEPTH];
   logic [lfm_pkg::MQ_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [lfm_pkg::MQ_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [lfm_pkg::MQ_CNT_W-1:0]        cnt_ff, cnt_in;
   logic                                do_push, do_pop;

   assign full    = (cnt_ff == lfm_pkg::MQ_CNT_W'(lfm_pkg::MQ_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop)
         cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push)
         cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

>>> src/lfm_back.sv
// ---------------------------------------------------------------------------
// lfm_back: PID arithmetic, mixer and result queue
// Four-stage pipeline: gain products, term sum, magnitude, divide by 100.
// The mixer and clamp feed a two-entry result queue.
// ---------------------------------------------------------------------------
module lfm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  lfm_pkg::cfg_type      cfg,
   input  lfm_pkg::mq_entry_type mq_data,
   input  logic                  mq_empty,
   output logic                  mq_pop,
   output lfm_pkg::rsp_type      rsp,
   output logic                  rsp_empty,
   input  logic                  rsp_pop
);

   // pipeline stage registers
   logic                              v1_ff, v2_ff, v3_ff, v4_ff;
   logic                              v1_in, v2_in, v3_in, v4_in;
   logic                              k1_ff, k2_ff, k3_ff, k4_ff;
   logic signed [lfm_pkg::P_W-1:0]    p_ff, p_in, d_ff, d_in;
   logic signed [lfm_pkg::I_W-1:0]    i_ff, i_in;
   logic signed [lfm_pkg::CORR_W-1:0] corr_ff, corr_in;
   logic [lfm_pkg::CORR_W-1:0]        mag_full;
   logic [lfm_pkg::MAG_W-1:0]         mag_ff, mag_in;
   logic                              big_ff, big_in, neg_ff, neg_in;
   logic [lfm_pkg::PROD_W-1:0]        prod;
   logic [lfm_pkg::Q_W-1:0]           q;
   logic signed [lfm_pkg::CQ_W-1:0]   cq_ff, cq_in;
   logic                              adv;

   // result queue
   lfm_pkg::rsp_type                  oq_ff [2];
   logic                              oq_wr_ff, oq_wr_in, oq_rd_ff, oq_rd_in;
   logic [1:0]                        oq_cnt_ff, oq_cnt_in;
   logic                              oq_full, oq_push, oq_pop;
   lfm_pkg::rsp_type                  mix;
   logic signed [lfm_pkg::MIX_W-1:0]  base_s, left_raw, right_raw;

   // whole pipeline holds when its last stage cannot drain
   assign oq_full = (oq_cnt_ff == 2'd2);
   assign adv     = !(v4_ff && oq_full);
   assign mq_pop  = adv && !mq_empty;
   assign oq_push = v4_ff && adv;

   // stage 1: gain products
   always_comb begin
      v1_in = mq_pop;
      p_in  = $signed({1'b0, cfg.prop_gain}) * mq_data.err;
      i_in  = $signed({1'b0, cfg.integ_gain}) * mq_data.sum;
      d_in  = $signed({1'b0, cfg.deriv_gain}) * mq_data.delta;
   end

   // stage 2: sum of terms
   always_comb begin
      v2_in   = v1_ff;
      corr_in = lfm_pkg::CORR_W'(p_ff) + lfm_pkg::CORR_W'(i_ff)
              + lfm_pkg::CORR_W'(d_ff);
   end

   // stage 3: sign, magnitude, saturation check
   always_comb begin
      v3_in    = v2_ff;
      neg_in   = corr_ff[lfm_pkg::CORR_W-1];
      mag_full = neg_in ? lfm_pkg::CORR_W'(-corr_ff) : lfm_pkg::CORR_W'(corr_ff);
      big_in   = (mag_full >= lfm_pkg::Q_LIMIT);
      mag_in   = mag_full[lfm_pkg::MAG_W-1:0];
   end

   // stage 4: divide by 100 through the reciprocal, truncate toward zero
   always_comb begin
      v4_in = v3_ff;
      prod  = lfm_pkg::PROD_W'(mag_ff) * lfm_pkg::PROD_W'(lfm_pkg::RECIP);
      q     = big_ff ? lfm_pkg::Q_MAX
                     : prod[lfm_pkg::RECIP_SHIFT +: lfm_pkg::Q_W];
      cq_in = neg_ff ? -$signed({1'b0, q}) : $signed({1'b0, q});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff    <= p_in;
         i_ff    <= i_in;
         d_ff    <= d_in;
         k1_ff   <= mq_data.known;
         corr_ff <= corr_in;
         k2_ff   <= k1_ff;
         mag_ff  <= mag_in;
         big_ff  <= big_in;
         neg_ff  <= neg_in;
         k3_ff   <= k2_ff;
         cq_ff   <= cq_in;
         k4_ff   <= k3_ff;
      end
   end

   // mixer and clamp
   always_comb begin
      base_s            = $signed({(lfm_pkg::MIX_W-lfm_pkg::GAIN_W)'(0), cfg.base_speed});
      left_raw          = base_s + lfm_pkg::MIX_W'(cq_ff);
      right_raw         = base_s - lfm_pkg::MIX_W'(cq_ff);
      mix.left_speed    = lfm_pkg::clamp_cmd(left_raw, cfg.speed_floor, cfg.speed_ceiling);
      mix.right_speed   = lfm_pkg::clamp_cmd(right_raw, cfg.speed_floor, cfg.speed_ceiling);
      mix.left_reverse  = mix.left_speed[lfm_pkg::SPD_W-1];
      mix.right_reverse = mix.right_speed[lfm_pkg::SPD_W-1];
      mix.left_duty     = lfm_pkg::duty_of(mix.left_speed);
      mix.right_duty    = lfm_pkg::duty_of(mix.right_speed);
      mix.pattern_known = k4_ff;
   end

   // result queue control
   assign rsp_empty = (oq_cnt_ff == 2'd0);
   assign oq_pop    = rsp_pop && !rsp_empty;
   assign rsp       = oq_ff[oq_rd_ff];

   always_comb begin
      oq_wr_in  = oq_push ? !oq_wr_ff : oq_wr_ff;
      oq_rd_in  = oq_pop  ? !oq_rd_ff : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff;
      if (oq_push && !oq_pop)
         oq_cnt_in = oq_cnt_ff + 2'd1;
      else if (oq_pop && !oq_push)
         oq_cnt_in = oq_cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push)
         oq_ff[oq_wr_ff] <= mix;
   end

endmodule

>>> src/line_follower_pid_motor_mixer.sv
// ---------------------------------------------------------------------------
// line_follower_pid_motor_mixer: line sensor PID with differential mixing
// Classifies a 7-bit sensor sample into a position error, runs a PID
// correction and mixes it into clamped left/right motor commands.
//
//   Channel  Ports                        Transfer when
//   -------  ---------------------------  ---------------------------
//   request  req_push/req_full, pattern   req_push && !req_full
//   response rsp_pop/rsp_empty, speeds    rsp_pop && !rsp_empty
//   csr      csr_we, csr_index, csr_wdata csr_we
//
// One sample per cycle sustained while the result queue drains. A request
// passes through the mid queue, then four back stages (products, sum,
// magnitude, reciprocal multiply) with mixing ahead of the result queue.
// Synchronous reset clears error state, queues and pipeline valids and
// loads the register defaults. A stalled result queue holds the back
// pipeline; the four-entry mid queue then absorbs input before req_full.
// ---------------------------------------------------------------------------
module line_follower_pid_motor_mixer (
   input  logic                                 clock,
   input  logic                                 reset,
   // request
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [lfm_pkg::PAT_W-1:0]            req_line_pattern,
   // response
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [lfm_pkg::SPD_W-1:0]     rsp_left_speed,
   output logic signed [lfm_pkg::SPD_W-1:0]     rsp_right_speed,
   output logic                                 rsp_left_reverse,
   output logic                                 rsp_right_reverse,
   output logic [lfm_pkg::DUTY_W-1:0]           rsp_left_duty,
   output logic [lfm_pkg::DUTY_W-1:0]           rsp_right_duty,
   output logic                                 rsp_pattern_known,
   // configuration
   input  logic                                 csr_we,
   input  logic [lfm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lfm_pkg::CSR_DAT_W-1:0]        csr_wdata
);

   lfm_pkg::cfg_type      cfg_ff, cfg_in;
   lfm_pkg::mq_entry_type mq_wr, mq_rd;
   lfm_pkg::rsp_type      rsp;
   logic                  mq_push, mq_full, mq_pop, mq_empty;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            lfm_pkg::CSR_PROP_GAIN:  cfg_in.prop_gain     = csr_wdata[lfm_pkg::GAIN_W-1:0];
            lfm_pkg::CSR_INTEG_GAIN: cfg_in.integ_gain    = csr_wdata[lfm_pkg::GAIN_W-1:0];
            lfm_pkg::CSR_DERIV_GAIN: cfg_in.deriv_gain    = csr_wdata[lfm_pkg::GAIN_W-1:0];
            lfm_pkg::CSR_BASE_SPEED: cfg_in.base_speed    = csr_wdata[lfm_pkg::GAIN_W-1:0];
            lfm_pkg::CSR_SPD_FLOOR:  cfg_in.speed_floor   = $signed(csr_wdata);
            lfm_pkg::CSR_SPD_CEIL:   cfg_in.speed_ceiling = csr_wdata[lfm_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain     <= 10'd140;
         cfg_ff.integ_gain    <= 10'd0;
         cfg_ff.deriv_gain    <= 10'd30;
         cfg_ff.base_speed    <= 10'd380;
         cfg_ff.speed_floor   <= -11'sd300;
         cfg_ff.speed_ceiling <= 10'd999;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lfm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_line_pattern (req_line_pattern),
      .mq_full          (mq_full),
      .mq_push          (mq_push),
      .mq_entry         (mq_wr)
   );

   lfm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (mq_push),
      .wr_data (mq_wr),
      .full    (mq_full),
      .pop     (mq_pop),
      .rd_data (mq_rd),
      .empty   (mq_empty)
   );

   lfm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .mq_data   (mq_rd),
      .mq_empty  (mq_empty),
      .mq_pop    (mq_pop),
      .rsp       (rsp),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_left_speed    = rsp.left_speed;
   assign rsp_right_speed   = rsp.right_speed;
   assign rsp_left_reverse  = rsp.left_reverse;
   assign rsp_right_reverse = rsp.right_reverse;
   assign rsp_left_duty     = rsp.left_duty;
   assign rsp_right_duty    = rsp.right_duty;
   assign rsp_pattern_known = rsp.pattern_known;

endmodule

>>> src/lfm_checker.sv
// ---------------------------------------------------------------------------
// lfm_checker: port-level checks for the line follower PID mixer
// Watches reset behavior, response consistency and the response hold rule.
// ---------------------------------------------------------------------------
module lfm_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_full,
   input  logic                             rsp_empty,
   input  logic                             rsp_pop,
   input  logic signed [lfm_pkg::SPD_W-1:0] rsp_left_speed,
   input  logic signed [lfm_pkg::SPD_W-1:0] rsp_right_speed,
   input  logic                             rsp_left_reverse,
   input  logic                             rsp_right_reverse,
   input  logic [lfm_pkg::DUTY_W-1:0]       rsp_left_duty,
   input  logic [lfm_pkg::DUTY_W-1:0]       rsp_right_duty
);

   // reset leaves the result queue empty and the mid queue not full
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // direction bits follow the command signs
   a_reverse: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_left_reverse == rsp_left_speed[lfm_pkg::SPD_W-1]) &&
                     (rsp_right_reverse == rsp_right_speed[lfm_pkg::SPD_W-1]))
      else $error("reverse bit does not match speed sign");

   // forward duty equals the command itself
   a_left_duty: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_left_reverse) |->
         (rsp_left_duty == rsp_left_speed[lfm_pkg::DUTY_W-1:0]))
      else $error("left duty mismatch");

   a_right_duty: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_right_reverse) |->
         (rsp_right_duty == rsp_right_speed[lfm_pkg::DUTY_W-1:0]))
      else $error("right duty mismatch");

   // a waiting result stays until transferred (checked on the left speed)
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_left_speed)))
      else $error("response dropped without transfer");

endmodule

bind line_follower_pid_motor_mixer lfm_checker u_lfm_checker (.*);
